/* src/hrhp_pkg.sv */
package hrhp_pkg;

  // default width of the running body offset counter
  localparam int unsigned OffsetBitsDefault = 32;

  // field widths
  localparam int unsigned ByteBits   = 8;
  localparam int unsigned KindBits   = 3;
  localparam int unsigned CodeBits   = 10;
  localparam int unsigned ReportBits = 32;
  localparam int unsigned OutDataBits = 56;  // 8 + 10 + 32 rounded up to bytes

  // largest status code, saturation point
  localparam logic [CodeBits-1:0] CodeMax = 10'd999;

  // characters that steer the parser
  localparam logic [ByteBits-1:0] ChCr    = 8'h0D;
  localparam logic [ByteBits-1:0] ChLf    = 8'h0A;
  localparam logic [ByteBits-1:0] ChColon = 8'h3A;
  localparam logic [ByteBits-1:0] ChSpace = 8'h20;
  localparam logic [ByteBits-1:0] ChTab   = 8'h09;
  localparam logic [ByteBits-1:0] ChZero  = 8'h30;
  localparam logic [ByteBits-1:0] ChNine  = 8'h39;

  typedef enum logic [KindBits-1:0] {
    EV_NONE     = 3'd0,
    EV_STATUS   = 3'd1,
    EV_NAME     = 3'd2,
    EV_NAME_END = 3'd3,
    EV_VALUE    = 3'd4,
    EV_LINE_END = 3'd5,
    EV_HDR_END  = 3'd6,
    EV_BODY     = 3'd7
  } event_kind_t;

  typedef enum logic [2:0] {
    PH_STATUS = 3'b001,
    PH_HEADER = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    SP_VERSION = 3'b001,
    SP_CODE    = 3'b010,
    SP_REST    = 3'b100
  } status_part_t;

  typedef struct packed {
    event_kind_t                 event_kind;
    logic [ByteBits-1:0]         event_byte;
    logic [CodeBits-1:0]         status_code;
    logic [ReportBits-1:0]       body_offset;
  } result_t;

endpackage

/* src/http_response_header_parser.sv */
// http response header parser
//
// s_axis: one byte of the response stream per transaction; tdata carries the
// byte, tuser flags the first byte of a new response (parser state is
// cleared before that byte is handled).
// m_axis: exactly one event per input transaction, in order; tuser carries
// the event kind, tdata the event byte, the current status code and the
// body offset.
//
// the event for a byte is registered in the output stage (main, or skid while main
// stalls) before m_axis. throughput: one byte per cycle while s_axis_tready is
// high; state update (digit multiply-add, offset increment) is combinational.
//
// a two-entry output stage (main register plus skid register) sits between
// the parser and m_axis, so s_axis_tready is a register and the parser keeps
// taking bytes while one event waits; when m_axis stalls with both entries
// full, s_axis_tready drops until the receiver takes an event.
//
// reset (rst, synchronous) puts the parser in the status line phase with
// the code and body offset cleared and empties the output stage.
module http_response_header_parser #(
  parameter int unsigned OFFSET_BITS = hrhp_pkg::OffsetBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [hrhp_pkg::ByteBits-1:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic                            s_axis_tuser,   // [0] new_response
  // event stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hrhp_pkg::OutDataBits-1:0] m_axis_tdata,  // [7:0] event_byte,
                                                          // [17:8] status_code,
                                                          // [49:18] body_offset,
                                                          // [55:50] zero
  output logic [hrhp_pkg::KindBits-1:0]   m_axis_tuser    // [2:0] event_kind
);

  import hrhp_pkg::*;

  // parser state
  phase_t                  phase, phase_next;
  status_part_t            status_part, status_part_next;
  logic                    digits_stopped, digits_stopped_next;
  logic                    in_value, in_value_next;
  logic                    skipping_space, skipping_space_next;
  logic                    at_line_start, at_line_start_next;
  logic                    cr_pending, cr_pending_next;
  logic [CodeBits-1:0]     code_value, code_value_next;
  logic [OFFSET_BITS-1:0]  offset_count, offset_count_next;

  // output stage
  result_t                 main_res, skid_res, res;
  logic                    main_valid, skid_valid;

  logic                    in_accept, out_take;
  logic [ByteBits-1:0]     b;
  logic [13:0]             code_sum;  // up to 999 * 10 + 9

  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_take      = main_valid & m_axis_tready;
  assign s_axis_tready = ~skid_valid;
  assign b             = s_axis_tdata;

  // one byte of parsing, done on the state as it stands after an optional
  // new-response clear
  always_comb begin
    phase_next          = phase;
    status_part_next    = status_part;
    digits_stopped_next = digits_stopped;
    in_value_next       = in_value;
    skipping_space_next = skipping_space;
    at_line_start_next  = at_line_start;
    cr_pending_next     = cr_pending;
    code_value_next     = code_value;
    offset_count_next   = offset_count;

    if (s_axis_tuser) begin
      phase_next          = PH_STATUS;
      status_part_next    = SP_VERSION;
      digits_stopped_next = 1'b0;
      in_value_next       = 1'b0;
      skipping_space_next = 1'b0;
      at_line_start_next  = 1'b1;
      cr_pending_next     = 1'b0;
      code_value_next     = '0;
      offset_count_next   = '0;
    end

    code_sum = 14'({4'b0, code_value_next} * 14'd10) + {10'b0, b[3:0]};

    res.event_kind  = EV_NONE;
    res.event_byte  = '0;
    res.body_offset = '0;

    if (phase_next == PH_BODY) begin
      res.event_kind    = EV_BODY;
      res.event_byte    = b;
      res.body_offset   = ReportBits'(offset_count_next);
      offset_count_next = offset_count_next + 1'b1;
    end else if (cr_pending_next && b == ChLf) begin
      // crlf closes the line
      cr_pending_next = 1'b0;
      if (at_line_start_next) begin
        // empty line: headers are done
        phase_next     = PH_BODY;
        res.event_kind = EV_HDR_END;
      end else if (phase_next == PH_STATUS) begin
        res.event_kind = EV_STATUS;
        // a zero code means another status line follows
        if (code_value_next != '0) begin
          phase_next = PH_HEADER;
        end
        status_part_next    = SP_VERSION;
        digits_stopped_next = 1'b0;
      end else begin
        res.event_kind = EV_LINE_END;
      end
      in_value_next       = 1'b0;
      skipping_space_next = 1'b0;
      at_line_start_next  = 1'b1;
    end else begin
      // a cr not followed by lf is dropped here
      cr_pending_next = 1'b0;
      if (b == ChCr) begin
        cr_pending_next = 1'b1;
      end else begin
        at_line_start_next = 1'b0;
        if (phase_next == PH_STATUS) begin
          case (status_part_next)
            SP_VERSION: begin
              if (b == ChSpace) begin
                status_part_next = SP_CODE;
              end
            end
            SP_CODE: begin
              if (b == ChSpace) begin
                status_part_next = SP_REST;
              end else if ((b inside {[ChZero:ChNine]}) && !digits_stopped_next) begin
                code_value_next = (code_sum > 14'(CodeMax)) ? CodeMax
                                                             : code_sum[CodeBits-1:0];
              end else begin
                digits_stopped_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (!in_value_next) begin
          // header name, split at the first colon
          if (b == ChColon) begin
            in_value_next       = 1'b1;
            skipping_space_next = 1'b1;
            res.event_kind      = EV_NAME_END;
          end else begin
            res.event_kind = EV_NAME;
            res.event_byte = b;
          end
        end else if (skipping_space_next && (b == ChSpace || b == ChTab)) begin
          // leading whitespace of the value
          res.event_kind = EV_NONE;
        end else begin
          skipping_space_next = 1'b0;
          res.event_kind      = EV_VALUE;
          res.event_byte      = b;
        end
      end
    end

    res.status_code = code_value_next;
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_STATUS;
      status_part    <= SP_VERSION;
      digits_stopped <= 1'b0;
      in_value       <= 1'b0;
      skipping_space <= 1'b0;
      at_line_start  <= 1'b1;
      cr_pending     <= 1'b0;
      code_value     <= '0;
      offset_count   <= '0;
    end else if (in_accept) begin
      phase          <= phase_next;
      status_part    <= status_part_next;
      digits_stopped <= digits_stopped_next;
      in_value       <= in_value_next;
      skipping_space <= skipping_space_next;
      at_line_start  <= at_line_start_next;
      cr_pending     <= cr_pending_next;
      code_value     <= code_value_next;
      offset_count   <= offset_count_next;
    end
  end

  // output stage control: main register feeds m_axis, skid catches an
  // event while main is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_take) begin
      main_valid <= skid_valid | in_accept;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  // output stage payload
  always_ff @(posedge clk) begin
    if (!main_valid || out_take) begin
      main_res <= skid_valid ? skid_res : res;
    end else if (in_accept) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = main_valid;
  assign m_axis_tuser  = main_res.event_kind;
  assign m_axis_tdata  = {6'b0, main_res.body_offset, main_res.status_code,
                          main_res.event_byte};

endmodule

/* tb/http_response_header_parser_tb.sv */
`timescale 1ns / 100ps

module http_response_header_parser_tb;
  import hrhp_pkg::*;

  localparam int StallLimit = 2000;  // cycles with no transaction before giving up
  localparam int HoldCycles = 300;   // long receiver hold-off
  localparam int PhaseItems = 256;   // random bytes per idling phase
  localparam int DirRows    = 28;

  logic clk = 1'b0;
  logic rst;

  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [ByteBits-1:0]    s_axis_tdata;   // [7:0] data_byte
  logic                   s_axis_tuser;   // [0] new_response
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;   // [7:0] event_byte, [17:8] status_code,
                                          // [49:18] body_offset, [55:50] zero
  logic [KindBits-1:0]    m_axis_tuser;   // [2:0] event_kind

  always #1 clk = ~clk;

  http_response_header_parser uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // events still owed by the parser, oldest first
  result_t pending_events[$];
  int      mismatch_count = 0;
  int      bytes_sent = 0;
  int      tx_idle_pct = 0;
  int      rx_stall_pct = 0;
  logic    hold_request = 1'b0;
  int      quiet_cycles = 0;

  // shadow copy of the parser state
  phase_t              ps_phase;
  status_part_t        ps_part;
  logic                digit_halt;
  logic                in_val;
  logic                skip_ws;
  logic                line_fresh;
  logic                cr_seen;
  logic [CodeBits-1:0] code_acc;
  logic [31:0]         byte_pos;

  function automatic void clear_parser();
    ps_phase   = PH_STATUS;
    ps_part    = SP_VERSION;
    digit_halt = 1'b0;
    in_val     = 1'b0;
    skip_ws    = 1'b0;
    line_fresh = 1'b1;
    cr_seen    = 1'b0;
    code_acc   = '0;
    byte_pos   = '0;
  endfunction

  // event that one received byte produces, advancing the shadow state
  function automatic result_t parse_byte_event(input logic [7:0] b, input logic nr);
    result_t ev;
    int      v;
    ev = '0;
    if (nr) clear_parser();
    if (ps_phase == PH_BODY) begin
      ev.event_kind  = EV_BODY;
      ev.event_byte  = b;
      ev.body_offset = byte_pos;
      byte_pos       = byte_pos + 32'd1;   // wraps with the 32 bit counter
    end else if (cr_seen && b == ChLf) begin
      // crlf closes the line
      cr_seen = 1'b0;
      if (line_fresh) begin
        ps_phase      = PH_BODY;
        ev.event_kind = EV_HDR_END;
      end else if (ps_phase == PH_STATUS) begin
        ev.event_kind = EV_STATUS;
        if (code_acc != '0) ps_phase = PH_HEADER;  // code 0: another status line
        ps_part    = SP_VERSION;
        digit_halt = 1'b0;
      end else begin
        ev.event_kind = EV_LINE_END;
      end
      in_val     = 1'b0;
      skip_ws    = 1'b0;
      line_fresh = 1'b1;
    end else begin
      // a cr not followed by lf is simply dropped
      cr_seen = 1'b0;
      if (b == ChCr) begin
        cr_seen = 1'b1;
      end else begin
        line_fresh = 1'b0;
        if (ps_phase == PH_STATUS) begin
          if (ps_part == SP_VERSION) begin
            if (b == ChSpace) ps_part = SP_CODE;
          end else if (ps_part == SP_CODE) begin
            if (b == ChSpace) begin
              ps_part = SP_REST;
            end else if (b >= ChZero && b <= ChNine && !digit_halt) begin
              v = int'(code_acc) * 10 + int'(b) - int'(ChZero);
              code_acc = (v > int'(CodeMax)) ? CodeMax : CodeBits'(v);
            end else begin
              digit_halt = 1'b1;
            end
          end
        end else if (!in_val) begin
          if (b == ChColon) begin
            in_val        = 1'b1;
            skip_ws       = 1'b1;
            ev.event_kind = EV_NAME_END;
          end else begin
            ev.event_kind = EV_NAME;
            ev.event_byte = b;
          end
        end else if (skip_ws && (b == ChSpace || b == ChTab)) begin
          ev.event_kind = EV_NONE;
        end else begin
          skip_ws       = 1'b0;
          ev.event_kind = EV_VALUE;
          ev.event_byte = b;
        end
      end
    end
    ev.status_code = code_acc;
    return ev;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // offer one byte, with random idle cycles ahead of it, and record its event
  task automatic send_byte(input logic [7:0] b, input logic nr,
                           input logic fixed = 1'b0, input result_t want = '0);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= nr;
    do @(posedge clk); while (!s_axis_tready);
    predicted = parse_byte_event(b, nr);
    pending_events.push_back(fixed ? want : predicted);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // crlf, now and then behind a bare cr that must be dropped
  task automatic send_eol();
    if ($urandom_range(19) == 0) send_byte(ChCr, 1'b0);
    send_byte(ChCr, 1'b0);
    send_byte(ChLf, 1'b0);
  endtask

  // one well-formed response with random content
  task automatic send_response();
    int         n_dig;
    int         n_hdr;
    int         n_len;
    logic       zeros;
    logic [7:0] c;
    send_byte(8'h48, ($urandom_range(9) != 0));
    send_text("TTP/1.1 ");
    n_dig = $urandom_range(4);
    zeros = ($urandom_range(3) == 0);
    for (int i = 0; i < n_dig; i++)
      send_byte(zeros ? ChZero : ChZero + 8'($urandom_range(9)), 1'b0);
    if ($urandom_range(4) == 0) begin
      // junk after the digits stops the code
      send_byte(8'h78, 1'b0);
      send_byte(ChZero + 8'($urandom_range(9)), 1'b0);
    end
    send_text(" OK");
    send_eol();
    n_hdr = $urandom_range(4);
    for (int h = 0; h < n_hdr; h++) begin
      n_len = $urandom_range(1, 6);
      for (int i = 0; i < n_len; i++) begin
        c = 8'($urandom_range(8'h21, 8'h7E));
        send_byte((c == ChColon) ? 8'h2D : c, 1'b0);
      end
      if ($urandom_range(6) != 0) begin
        send_byte(ChColon, 1'b0);
        n_len = $urandom_range(3);
        for (int i = 0; i < n_len; i++)
          send_byte($urandom_range(1) ? ChSpace : ChTab, 1'b0);
        n_len = $urandom_range(8);
        for (int i = 0; i < n_len; i++) begin
          c = 8'($urandom_range(255));
          if (c == ChCr && $urandom_range(3) != 0) c = 8'h41;
          send_byte(c, 1'b0);
        end
      end
      send_eol();
    end
    send_eol();
    n_len = $urandom_range(24);
    for (int i = 0; i < n_len; i++) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic drain_events();
    while (pending_events.size() != 0) @(negedge clk);
  endtask

  typedef struct packed {
    logic [7:0] b;
    logic       nr;
    logic       fixed;
    result_t    want;
  } dir_row_t;

  // directed bytes; rows with fixed set carry an event typed in by hand
  localparam dir_row_t DirTable [DirRows] = '{
    '{8'h48,   1'b1, 1'b1, '{EV_NONE, 8'h00, 10'd0, 32'd0}},    // new response
    '{ChSpace, 1'b0, 1'b0, '0},
    '{8'h39,   1'b0, 1'b0, '0},
    '{8'h39,   1'b0, 1'b0, '0},
    '{8'h39,   1'b0, 1'b0, '0},
    '{8'h39,   1'b0, 1'b1, '{EV_NONE, 8'h00, CodeMax, 32'd0}},  // code saturates
    '{8'h78,   1'b0, 1'b0, '0},                                 // stops the digits
    '{8'h35,   1'b0, 1'b0, '0},
    '{ChCr,    1'b0, 1'b0, '0},
    '{ChCr,    1'b0, 1'b0, '0},                                 // first cr was bare
    '{ChLf,    1'b0, 1'b1, '{EV_STATUS, 8'h00, CodeMax, 32'd0}},
    '{ChColon, 1'b0, 1'b0, '0},                                 // empty name
    '{ChTab,   1'b0, 1'b0, '0},
    '{ChSpace, 1'b0, 1'b0, '0},
    '{8'hFF,   1'b0, 1'b1, '{EV_VALUE, 8'hFF, CodeMax, 32'd0}},
    '{ChSpace, 1'b0, 1'b0, '0},                                 // space inside the value
    '{ChLf,    1'b0, 1'b0, '0},                                 // lone lf is a value byte
    '{ChCr,    1'b0, 1'b0, '0},
    '{ChLf,    1'b0, 1'b0, '0},
    '{8'h00,   1'b0, 1'b1, '{EV_NAME, 8'h00, CodeMax, 32'd0}},  // line without colon
    '{ChCr,    1'b0, 1'b0, '0},
    '{ChLf,    1'b0, 1'b0, '0},
    '{ChCr,    1'b0, 1'b0, '0},
    '{ChLf,    1'b0, 1'b1, '{EV_HDR_END, 8'h00, CodeMax, 32'd0}},
    '{ChCr,    1'b0, 1'b1, '{EV_BODY, ChCr, CodeMax, 32'd0}},   // cr in the body
    '{8'hFF,   1'b0, 1'b0, '0},
    '{ChCr,    1'b1, 1'b0, '0},                                 // empty line in status phase
    '{ChLf,    1'b0, 1'b1, '{EV_HDR_END, 8'h00, 10'd0, 32'd0}}
  };

  // idling phases: none, sender only, receiver only, both
  localparam int TxPct [4] = '{0, 69, 0, 27};
  localparam int RxPct [4] = '{0, 0, 69, 27};

  initial begin : stimulus
    int n_noise;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    clear_parser();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DirRows; i++)
      send_byte(DirTable[i].b, DirTable[i].nr, DirTable[i].fixed, DirTable[i].want);
    s_axis_tvalid <= 1'b0;
    drain_events();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = TxPct[p];
      rx_stall_pct = RxPct[p];
      // receiver hold-off while the sender keeps offering: fills the output stage
      if (p == 2) hold_request = 1'b1;
      while (bytes_sent < DirRows + (p + 1) * PhaseItems) begin
        if ($urandom_range(11) == 0) begin
          n_noise = $urandom_range(1, 6);
          for (int i = 0; i < n_noise; i++)
            send_byte(8'($urandom_range(255)), ($urandom_range(9) == 0));
        end else begin
          send_response();
        end
      end
      // sender pauses until every event has come back
      s_axis_tvalid <= 1'b0;
      drain_events();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("http_response_header_parser: match");
    end else begin
      $display("http_response_header_parser: mismatch");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int   hold_left;
    logic hold_taken;
    hold_left     = 0;
    hold_taken    = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_left  = HoldCycles;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // compare each event transaction with the oldest expected event
  always @(posedge clk) begin : event_check
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[17:8], m_axis_tdata[49:18]};
      if (pending_events.size() == 0) begin
        report_mismatch("event with none expected, kind", got.event_kind, 0);
      end else begin
        want = pending_events.pop_front();
        if (got.event_kind != want.event_kind)
          report_mismatch("event_kind", got.event_kind, want.event_kind);
        if (got.event_byte != want.event_byte)
          report_mismatch("event_byte", got.event_byte, want.event_byte);
        if (got.status_code != want.status_code)
          report_mismatch("status_code", got.status_code, want.status_code);
        if (got.body_offset != want.body_offset)
          report_mismatch("body_offset", got.body_offset, want.body_offset);
      end
      if (m_axis_tdata[55:50] != '0)
        report_mismatch("tdata padding", m_axis_tdata[55:50], 0);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("http_response_header_parser: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* files.f */
src/hrhp_pkg.sv
src/http_response_header_parser.sv
tb/http_response_header_parser_tb.sv
